### src/gost_pkg.sv
// Shared types, constants and the round function of the 64-bit GOST block cipher.
// No dependencies; used by gost_cell and gost_block_cipher_64_top.
package gost_pkg;

  localparam int ROUNDS   = 32;
  localparam int SUBKEYS  = 8;
  localparam int HALF_W   = 32;
  localparam int ROT_AMT  = 11;
  localparam int KIDX_W   = $clog2(SUBKEYS);

  typedef enum logic {
    CMD_ENCRYPT = 1'b0,
    CMD_DECRYPT = 1'b1
  } gost_cmd_t;

  typedef struct packed {
    logic              cmd;
    logic [HALF_W-1:0] n1;
    logic [HALF_W-1:0] n2;
  } gost_blk_t;

  localparam logic [3:0] SBOX [SUBKEYS][16] = '{
    '{4'h4, 4'h2, 4'hf, 4'h5, 4'h9, 4'h1, 4'h0, 4'h8,
      4'he, 4'h3, 4'hb, 4'hc, 4'hd, 4'h7, 4'ha, 4'h6},
    '{4'hc, 4'h9, 4'hf, 4'he, 4'h8, 4'h1, 4'h3, 4'ha,
      4'h2, 4'h7, 4'h4, 4'hd, 4'h6, 4'h0, 4'hb, 4'h5},
    '{4'hd, 4'h8, 4'he, 4'hc, 4'h7, 4'h3, 4'h9, 4'ha,
      4'h1, 4'h5, 4'h2, 4'h4, 4'h6, 4'hf, 4'h0, 4'hb},
    '{4'he, 4'h9, 4'hb, 4'h2, 4'h5, 4'hf, 4'h7, 4'h1,
      4'h0, 4'hd, 4'hc, 4'h6, 4'ha, 4'h4, 4'h3, 4'h8},
    '{4'h3, 4'he, 4'h5, 4'h9, 4'h6, 4'h8, 4'h0, 4'hd,
      4'ha, 4'hb, 4'h7, 4'hc, 4'h2, 4'h1, 4'hf, 4'h4},
    '{4'h8, 4'hf, 4'h6, 4'hb, 4'h1, 4'h9, 4'hc, 4'h5,
      4'hd, 4'h3, 4'h7, 4'ha, 4'h0, 4'he, 4'h2, 4'h4},
    '{4'h9, 4'hb, 4'hc, 4'h0, 4'h3, 4'h6, 4'h7, 4'h5,
      4'h4, 4'h8, 4'he, 4'hf, 4'h1, 4'ha, 4'h2, 4'hd},
    '{4'hc, 4'h6, 4'h5, 4'h2, 4'hb, 4'h0, 4'h9, 4'hd,
      4'h3, 4'he, 4'h7, 4'ha, 4'hf, 4'h4, 4'h1, 4'h8}
  };

  function automatic logic [HALF_W-1:0] round_f(input logic [HALF_W-1:0] half,
                                                input logic [HALF_W-1:0] key);
    logic [HALF_W-1:0] sum;
    logic [HALF_W-1:0] sub;
    sum = half + key;
    for (int i = 0; i < SUBKEYS; i++) begin
      sub[4*i +: 4] = SBOX[i][sum[4*i +: 4]];
    end
    return {sub[HALF_W-ROT_AMT-1:0], sub[HALF_W-1:HALF_W-ROT_AMT]};
  endfunction

endpackage

### src/gost_cell.sv
// One Feistel round cell of the cipher pipeline: round logic and its stage register.
// Depends on gost_pkg for the block type and the round function.
module gost_cell #(
  parameter int ROUND = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      up_valid,
  input  gost_pkg::gost_blk_t       up_data,
  output logic                      up_ready,
  input  logic [gost_pkg::HALF_W-1:0] key_fwd,
  input  logic [gost_pkg::HALF_W-1:0] key_rev,
  output logic                      dn_valid,
  output gost_pkg::gost_blk_t       dn_data,
  input  logic                      dn_ready
);
  import gost_pkg::*;

  localparam int   PASS    = ROUND / SUBKEYS;
  localparam logic ENC_FWD = (PASS < 3);
  localparam logic DEC_FWD = (PASS == 0);

  logic              fwd;
  logic [HALF_W-1:0] key;
  gost_blk_t         dn_data_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    fwd                = (up_data.cmd == CMD_DECRYPT) ? DEC_FWD : ENC_FWD;
    key                = fwd ? key_fwd : key_rev;
    dn_data_next.cmd   = up_data.cmd;
    dn_data_next.n1    = up_data.n2 ^ round_f(up_data.n1, key);
    dn_data_next.n2    = up_data.n1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= dn_data_next;
    end
  end

endmodule

### src/gost_block_cipher_64_top.sv
// Top level of the 64-bit GOST block cipher: subkey registers and a chain of 32 round cells.
// Depends on gost_pkg and gost_cell.
// Each accepted request passes through all 32 cells, one round per cell.
// Throughput: one request per cycle while the output is not stalled; the last cell's register is the output register.
// A stalled output holds only the cells behind it that are full; empty cells still take requests.
// Reset clears every cell's valid bit and all eight subkeys to zero.
module gost_block_cipher_64_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  logic                                cmd,
  input  logic [31:0]                         block_low,
  input  logic [31:0]                         block_high,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic [31:0]                         result_low,
  output logic [31:0]                         result_high,
  input  logic                                cfg_we,
  input  logic [gost_pkg::KIDX_W-1:0]         cfg_index,
  input  logic [31:0]                         cfg_data
);
  import gost_pkg::*;

  logic [HALF_W-1:0] subkey [SUBKEYS];
  logic              stage_valid [ROUNDS+1];
  logic              stage_ready [ROUNDS+1];
  gost_blk_t         stage_data  [ROUNDS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SUBKEYS; i++) begin
        subkey[i] <= '0;
      end
    end else if (cfg_we) begin
      subkey[cfg_index] <= cfg_data;
    end
  end

  assign stage_valid[0]     = req_valid;
  assign stage_data[0].cmd  = cmd;
  assign stage_data[0].n1   = block_low;
  assign stage_data[0].n2   = block_high;
  assign req_stall          = !stage_ready[0];

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    gost_cell #(
      .ROUND (r)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[r]),
      .up_data  (stage_data[r]),
      .up_ready (stage_ready[r]),
      .key_fwd  (subkey[r % SUBKEYS]),
      .key_rev  (subkey[SUBKEYS - 1 - (r % SUBKEYS)]),
      .dn_valid (stage_valid[r+1]),
      .dn_data  (stage_data[r+1]),
      .dn_ready (stage_ready[r+1])
    );
  end

  assign stage_ready[ROUNDS] = !rsp_stall;
  assign rsp_valid           = stage_valid[ROUNDS];
  assign result_low          = stage_data[ROUNDS].n2;
  assign result_high         = stage_data[ROUNDS].n1;

`ifndef SYNTHESIS
  logic [ROUNDS-1:0] full_vec;
  logic              acc_in;
  logic              acc_out;

  always_comb begin
    for (int i = 0; i < ROUNDS; i++) begin
      full_vec[i] = stage_valid[i+1];
    end
  end

  assign acc_in  = req_valid && !req_stall;
  assign acc_out = rsp_valid && !rsp_stall;

  a_item_count: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> $countones(full_vec) ==
      $past($countones(full_vec)) + int'($past(acc_in)) - int'($past(acc_out)))
    else $error("request count in the cell chain does not balance");

  a_no_backpressure: assert property (@(posedge clk) disable iff (rst)
    !rsp_stall |-> !req_stall)
    else $error("request stalled while the output is free");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && $countones(full_vec) == 0)
    else $error("cell chain not empty after reset");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> $countones(full_vec) == ROUNDS && rsp_stall)
    else $error("request stalled with room in the cell chain");
`endif

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for gost_block_cipher_64_top: 64-bit block encrypt and decrypt.
// Depends on gost_pkg for the command type and subkey index width and on the cipher RTL; everything else is local.
module tb_top;
  import gost_pkg::*;

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
  } cipher_block_t;

  typedef struct {
    gost_cmd_t   op;
    logic [31:0] lo;
    logic [31:0] hi;
  } block_request_t;

  typedef enum logic [2:0] {
    LOAD_STEADY,
    LOAD_SENDER_IDLE,
    LOAD_RECEIVER_STALL,
    LOAD_BOTH_IDLE,
    LOAD_HOLD_OFF
  } traffic_t;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 320;
  localparam int HOLD_ITEMS = 120;

  localparam logic [3:0] SUBST [8][16] = '{
    '{4'h4, 4'h2, 4'hf, 4'h5, 4'h9, 4'h1, 4'h0, 4'h8, 4'he, 4'h3, 4'hb, 4'hc, 4'hd, 4'h7,
      4'ha, 4'h6},
    '{4'hc, 4'h9, 4'hf, 4'he, 4'h8, 4'h1, 4'h3, 4'ha, 4'h2, 4'h7, 4'h4, 4'hd, 4'h6, 4'h0,
      4'hb, 4'h5},
    '{4'hd, 4'h8, 4'he, 4'hc, 4'h7, 4'h3, 4'h9, 4'ha, 4'h1, 4'h5, 4'h2, 4'h4, 4'h6, 4'hf,
      4'h0, 4'hb},
    '{4'he, 4'h9, 4'hb, 4'h2, 4'h5, 4'hf, 4'h7, 4'h1, 4'h0, 4'hd, 4'hc, 4'h6, 4'ha, 4'h4,
      4'h3, 4'h8},
    '{4'h3, 4'he, 4'h5, 4'h9, 4'h6, 4'h8, 4'h0, 4'hd, 4'ha, 4'hb, 4'h7, 4'hc, 4'h2, 4'h1,
      4'hf, 4'h4},
    '{4'h8, 4'hf, 4'h6, 4'hb, 4'h1, 4'h9, 4'hc, 4'h5, 4'hd, 4'h3, 4'h7, 4'ha, 4'h0, 4'he,
      4'h2, 4'h4},
    '{4'h9, 4'hb, 4'hc, 4'h0, 4'h3, 4'h6, 4'h7, 4'h5, 4'h4, 4'h8, 4'he, 4'hf, 4'h1, 4'ha,
      4'h2, 4'hd},
    '{4'hc, 4'h6, 4'h5, 4'h2, 4'hb, 4'h0, 4'h9, 4'hd, 4'h3, 4'he, 4'h7, 4'ha, 4'hf, 4'h4,
      4'h1, 4'h8}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  logic                cmd = 1'b0;
  logic [31:0]         block_low = '0;
  logic [31:0]         block_high = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  logic [31:0]         result_low;
  logic [31:0]         result_high;
  logic                cfg_we = 1'b0;
  logic [KIDX_W-1:0]   cfg_index = '0;
  logic [31:0]         cfg_data = '0;

  logic [31:0]         key_shadow [8] = '{default: 32'h0};
  cipher_block_t       awaited_blocks [$];
  cipher_block_t       due;
  traffic_t            traffic = LOAD_STEADY;
  traffic_t            prev_traffic = LOAD_STEADY;
  int                  send_gap_pct = 0;
  int                  hold_left = 0;
  int                  quiet_cycles = 0;
  int                  faults = 0;

  block_request_t corner_rows [16] = '{
    '{CMD_ENCRYPT, 32'h0000_0000, 32'h0000_0000},
    '{CMD_DECRYPT, 32'h0000_0000, 32'h0000_0000},
    '{CMD_ENCRYPT, 32'hffff_ffff, 32'hffff_ffff},
    '{CMD_DECRYPT, 32'hffff_ffff, 32'hffff_ffff},
    '{CMD_ENCRYPT, 32'h0000_0000, 32'hffff_ffff},
    '{CMD_DECRYPT, 32'hffff_ffff, 32'h0000_0000},
    '{CMD_ENCRYPT, 32'h0000_0001, 32'h0000_0000},
    '{CMD_DECRYPT, 32'h0000_0000, 32'h0000_0001},
    '{CMD_ENCRYPT, 32'h8000_0000, 32'h8000_0000},
    '{CMD_DECRYPT, 32'h8000_0000, 32'h0000_0000},
    '{CMD_ENCRYPT, 32'ha5a5_a5a5, 32'h5a5a_5a5a},
    '{CMD_DECRYPT, 32'h5a5a_5a5a, 32'ha5a5_a5a5},
    '{CMD_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef},
    '{CMD_DECRYPT, 32'hfedc_ba98, 32'h7654_3210},
    '{CMD_ENCRYPT, 32'hffff_fffe, 32'h7fff_ffff},
    '{CMD_DECRYPT, 32'h0000_0001, 32'hffff_fffe}
  };

  gost_block_cipher_64_top dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .cmd         (cmd),
    .block_low   (block_low),
    .block_high  (block_high),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .result_low  (result_low),
    .result_high (result_high),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Thirty-two Feistel rounds with the current subkeys; the halves come out swapped.
  function automatic cipher_block_t gost_rounds(gost_cmd_t op, logic [31:0] lo,
                                                logic [31:0] hi);
    logic [31:0] left;
    logic [31:0] right;
    logic [31:0] sum;
    logic [31:0] sub;
    logic [31:0] mixed;
    int          r;
    int          n;
    int          k;
    left = lo;
    right = hi;
    for (r = 0; r < 32; r++) begin
      if ((op == CMD_DECRYPT) ? (r < 8) : (r < 24)) begin
        k = r % 8;
      end else begin
        k = 7 - (r % 8);
      end
      sum = left + key_shadow[k];
      for (n = 0; n < 8; n++) begin
        sub[4*n +: 4] = SUBST[n][sum[4*n +: 4]];
      end
      mixed = right ^ {sub[20:0], sub[31:21]};
      right = left;
      left = mixed;
    end
    return '{lo: right, hi: left};
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h1 << $urandom_range(31);
      3: return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic report_fault(string msg);
    $display("%0t: %s", $realtime, msg);
    faults++;
  endtask

  task automatic load_key(logic [31:0] words [8]);
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= i[KIDX_W-1:0];
      cfg_data <= words[i];
      key_shadow[i] = words[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic offer_request(gost_cmd_t op, logic [31:0] lo, logic [31:0] hi);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    cmd <= op;
    block_low <= lo;
    block_high <= hi;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    awaited_blocks.push_back(gost_rounds(op, lo, hi));
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (awaited_blocks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic run_corners();
    int i;
    for (i = 0; i < 16; i++) begin
      offer_request(corner_rows[i].op, corner_rows[i].lo, corner_rows[i].hi);
    end
    drain();
  endtask

  task automatic run_random(int count);
    int i;
    for (i = 0; i < count; i++) begin
      offer_request($urandom_range(1) ? CMD_DECRYPT : CMD_ENCRYPT, pick_word(), pick_word());
    end
    drain();
  endtask

  // Response side: checks each accepted result and decides the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (awaited_blocks.size() == 0) begin
        report_fault($sformatf("unexpected result %h_%h", result_high, result_low));
      end else begin
        due = awaited_blocks.pop_front();
        if (result_low !== due.lo) begin
          report_fault($sformatf("result_low got %h expected %h", result_low, due.lo));
        end
        if (result_high !== due.hi) begin
          report_fault($sformatf("result_high got %h expected %h", result_high, due.hi));
        end
      end
    end
    if (traffic == LOAD_HOLD_OFF && prev_traffic != LOAD_HOLD_OFF) begin
      hold_left = HOLD_OFF_CYCLES;
    end
    prev_traffic = traffic;
    if (hold_left > 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      case (traffic)
        LOAD_RECEIVER_STALL: rsp_stall <= ($urandom_range(99) < 52);
        LOAD_BOTH_IDLE:      rsp_stall <= ($urandom_range(99) < 25);
        default:             rsp_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [31:0] words [8];
    traffic_t    plan [4];
    int          p;
    int          i;
    plan = '{LOAD_STEADY, LOAD_SENDER_IDLE, LOAD_RECEIVER_STALL, LOAD_BOTH_IDLE};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The corner requests run first with the all-zero key left by reset.
    run_corners();
    words = '{default: 32'hffff_ffff};
    load_key(words);
    run_corners();
    words = '{32'h0000_0000, 32'hffff_ffff, 32'h0000_0001, 32'h8000_0000,
              32'h7fff_ffff, 32'hffff_fffe, 32'h0000_0000, 32'hffff_ffff};
    load_key(words);
    run_corners();

    for (p = 0; p < 4; p++) begin
      for (i = 0; i < 8; i++) begin
        words[i] = pick_word();
      end
      load_key(words);
      traffic <= plan[p];
      send_gap_pct = (plan[p] == LOAD_SENDER_IDLE) ? 52 : (plan[p] == LOAD_BOTH_IDLE) ? 25 : 0;
      run_random(PHASE_ITEMS);
    end

    // The receiver holds off for a long stretch while requests keep coming, so the
    // pipeline fills and pushes back on the sender.
    for (i = 0; i < 8; i++) begin
      words[i] = $urandom;
    end
    load_key(words);
    send_gap_pct = 0;
    traffic <= LOAD_HOLD_OFF;
    run_random(HOLD_ITEMS);

    traffic <= LOAD_BOTH_IDLE;
    repeat (40) @(posedge clk);
    if (faults == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
